// ===== src/sm3c_pkg.sv =====
// Shared types, constants and rotate/permutation functions for the SM3 compression unit.
package sm3c_pkg;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ABSORB = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;

    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam logic [5:0] LAST_ROUND = 6'd63;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] word;
        logic [2:0]  word_index;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_position;
        logic        last;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_READ
    } state_t;

    typedef struct packed {
        logic       load_cv;
        logic       absorb;
        logic       start;
        logic       round_en;
        logic       last_round;
        logic [5:0] round_idx;
        logic       emit;
        logic [2:0] emit_pos;
    } dp_cmd_t;

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] amt);
        rol32 = (x << amt) | (x >> (6'd32 - {1'b0, amt}));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        perm0 = x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        perm1 = x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
    endfunction

endpackage

// ===== src/sm3c_datapath.sv =====
// Chaining value, message window with expansion, round logic and output register.
module sm3c_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  sm3c_pkg::dp_cmd_t   cmd,
    input  sm3c_pkg::in_word_t  in_data,
    output sm3c_pkg::out_word_t out_data
);
    import sm3c_pkg::*;

    logic [31:0] cv_reg   [8];
    logic [31:0] cv_next  [8];
    logic [31:0] win_reg  [16];
    logic [31:0] win_next [16];
    logic [31:0] work_reg [8];
    logic [31:0] work_next[8];
    logic [31:0] rnd_out  [8];
    out_word_t   out_reg;
    out_word_t   out_next;

    logic [31:0] tj;
    logic [31:0] a12;
    logic [31:0] ss1;
    logic [31:0] ss2;
    logic [31:0] ff;
    logic [31:0] gg;
    logic [31:0] tt1;
    logic [31:0] tt2;
    logic [31:0] w_new;
    logic        early;

    // one SM3 round plus one step of message expansion
    always_comb
    begin
        early = (cmd.round_idx[5:4] == 2'b00);
        tj    = early ? T_LOW : T_HIGH;
        a12   = rol32(work_reg[0], 5'd12);
        ss1   = rol32(a12 + work_reg[4] + rol32(tj, cmd.round_idx[4:0]), 5'd7);
        ss2   = ss1 ^ a12;
        if (early)
        begin
            ff = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            gg = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            ff = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
                 | (work_reg[1] & work_reg[2]);
            gg = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        tt1 = ff + work_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + work_reg[7] + ss1 + win_reg[0];
        rnd_out[0] = tt1;
        rnd_out[1] = work_reg[0];
        rnd_out[2] = rol32(work_reg[1], 5'd9);
        rnd_out[3] = work_reg[2];
        rnd_out[4] = perm0(tt2);
        rnd_out[5] = work_reg[4];
        rnd_out[6] = rol32(work_reg[5], 5'd19);
        rnd_out[7] = work_reg[6];
        w_new = perm1(win_reg[0] ^ win_reg[7] ^ rol32(win_reg[13], 5'd15))
                ^ rol32(win_reg[3], 5'd7) ^ win_reg[10];
    end

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            win_next[i] = win_reg[i];
        end
        // slide the window: newest word enters at the top
        if (cmd.absorb || cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = cmd.absorb ? in_data.word : w_new;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            work_next[i] = work_reg[i];
            cv_next[i]   = cv_reg[i];
            if (cmd.start)
            begin
                work_next[i] = cv_reg[i];
            end
            else if (cmd.round_en)
            begin
                work_next[i] = rnd_out[i];
            end
            if (cmd.round_en && cmd.last_round)
            begin
                cv_next[i] = cv_reg[i] ^ rnd_out[i];
            end
        end
        if (cmd.load_cv)
        begin
            cv_next[in_data.word_index] = in_data.word;
        end
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.emit)
        begin
            out_next.digest_word     = cv_reg[cmd.emit_pos];
            out_next.digest_position = cmd.emit_pos;
            out_next.last            = &cmd.emit_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= SM3_IV[i];
            end
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= cv_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 16; i++)
        begin
            win_reg[i] <= win_next[i];
        end
        for (int i = 0; i < 8; i++)
        begin
            work_reg[i] <= work_next[i];
        end
        out_reg <= out_next;
    end

    assign out_data = out_reg;

endmodule

// ===== src/sm3c_ctrl.sv =====
// Controller: input handshake, word count, round sequencing and digest read-out.
module sm3c_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_kind,
    output logic               out_valid,
    input  logic               out_ready,
    output sm3c_pkg::dp_cmd_t  cmd
);
    import sm3c_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic [5:0] round_reg;
    logic [5:0] round_next;
    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_kind == KIND_ABSORB && (&count_reg))
                begin
                    state_next = ST_ROUND;
                end
                else if (accept && in_kind == KIND_READ)
                begin
                    state_next = ST_READ;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (slot_free && (&pos_reg))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.round_idx  = round_reg;
        cmd.emit_pos   = pos_reg;
        count_next     = count_reg;
        round_next     = round_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_kind == KIND_LOAD)
                begin
                    cmd.load_cv = 1'b1;
                end
                if (accept && in_kind == KIND_ABSORB)
                begin
                    cmd.absorb = 1'b1;
                    cmd.start  = &count_reg;
                    count_next = count_reg + 4'd1;
                end
                round_next = '0;
                pos_next   = '0;
            end
            ST_ROUND:
            begin
                cmd.round_en   = 1'b1;
                cmd.last_round = (round_reg == LAST_ROUND);
                round_next     = round_reg + 6'd1;
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    pos_next       = pos_reg + 3'd1;
                end
            end
            default:
            begin
                round_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            round_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> !in_ready)
        else $error("input ready during compression");

    a_block_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind == KIND_ABSORB && (&count_reg))
        |=> (state_reg == ST_ROUND && round_reg == 6'd0 && count_reg == 4'd0))
        else $error("sixteenth word did not start rounds");

    a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == LAST_ROUND) |=> (state_reg == ST_IDLE))
        else $error("compression did not end after last round");

    a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (&pos_reg)) |=> (state_reg == ST_IDLE && out_valid_reg))
        else $error("digest read-out did not finish on eighth word");
`endif

endmodule

// ===== src/sm3_compression_unit.sv =====
// Top level of the SM3 compression unit: controller plus datapath.
// The sixteenth absorbed word starts 64 rounds (one round per cycle) during which no input is
// taken. A digest read emits eight words, one per cycle while out_ready is high; the first
// word is registered in the output once the controller has entered its read state and the
// output slot is free, and input resumes after the eighth.
// Reset is asynchronous: the chaining value returns to the SM3 IV, the word count to zero.
module sm3_compression_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sm3c_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sm3c_pkg::out_word_t out_data
);
    import sm3c_pkg::*;

    dp_cmd_t cmd;

    sm3c_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_kind   (in_data.kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sm3c_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

// ===== sim/sm3_compression_unit_tb.sv =====
// Self-checking testbench for the SM3 compression unit with a built-in SM3 model.
`timescale 1ns / 1ps

module sm3_compression_unit_tb;
    import sm3c_pkg::*;

    localparam logic [1:0]  KIND_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 215;
    localparam logic [31:0] T_EARLY      = 32'h79CC4519;
    localparam logic [31:0] T_LATE       = 32'h7A879D8A;
    localparam logic [31:0] START_VALUE [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    logic [31:0] chain_model [8];
    logic [31:0] block_words [16];
    logic [3:0]  block_fill;
    out_word_t   pending_digest [$];
    out_word_t   due_word;

    int errors          = 0;
    int cycle_count     = 0;
    int burst_left      = 0;
    bit sender_steady   = 1'b0;
    bit rx_steady       = 1'b0;
    int rx_hold_request = 0;

    sm3_compression_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        logic [63:0] twice;
        twice = {x, x} << (n % 32);
        return twice[63:32];
    endfunction

    function automatic logic [31:0] mix_p0(input logic [31:0] x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [31:0] mix_p1(input logic [31:0] x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    // Expand the window, run 64 rounds on a copy of the chaining value, fold back in.
    function automatic void sm3_fold_block();
        logic [31:0] w [68];
        logic [31:0] v [8];
        logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
        int j;
        int r;
        for (j = 0; j < 16; j++)
            w[j] = block_words[j];
        for (j = 16; j < 68; j++)
            w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
        v = chain_model;
        for (r = 0; r < 64; r++)
        begin
            tj  = (r < 16) ? T_EARLY : T_LATE;
            a12 = rotl(v[0], 12);
            ss1 = rotl(a12 + v[4] + rotl(tj, r), 7);
            ss2 = ss1 ^ a12;
            if (r < 16)
            begin
                ff = v[0] ^ v[1] ^ v[2];
                gg = v[4] ^ v[5] ^ v[6];
            end
            else
            begin
                ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                gg = (v[4] & v[5]) | (~v[4] & v[6]);
            end
            tt1  = ff + v[3] + ss2 + (w[r] ^ w[r+4]);
            tt2  = gg + v[7] + ss1 + w[r];
            v[3] = v[2];
            v[2] = rotl(v[1], 9);
            v[1] = v[0];
            v[0] = tt1;
            v[7] = v[6];
            v[6] = rotl(v[5], 19);
            v[5] = v[4];
            v[4] = mix_p0(tt2);
        end
        for (j = 0; j < 8; j++)
            chain_model[j] ^= v[j];
    endfunction

    function automatic void track_word(input in_word_t w);
        out_word_t d;
        case (w.kind)
            KIND_LOAD:
                chain_model[w.word_index] = w.word;
            KIND_ABSORB:
            begin
                block_words[block_fill] = w.word;
                block_fill = block_fill + 4'd1;
                if (block_fill == 4'd0)
                    sm3_fold_block();
            end
            KIND_READ:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    d.digest_word     = chain_model[k];
                    d.digest_position = 3'(k);
                    d.last            = (k == 7);
                    pending_digest.push_back(d);
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one word; gaps open only between bursts.
    task automatic send_word(input logic [1:0] kind, input logic [31:0] word,
                             input logic [2:0] idx);
        in_word_t item;
        int gap;
        item.kind       = kind;
        item.word       = word;
        item.word_index = idx;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(12, 1);
            gap = sender_steady ? 0 : $urandom_range(6, 0);
            if (!sender_steady && $urandom_range(9) == 0)
                gap = $urandom_range(90, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_word(item);
    endtask

    // Drop valid and hold until every digest word has come back.
    task automatic wait_for_digests();
        in_valid <= 1'b0;
        while (pending_digest.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_digest.size() == 0)
            begin
                $display("%0t: unexpected digest word %h pos %0d last %b", $time,
                         out_data.digest_word, out_data.digest_position, out_data.last);
                errors++;
            end
            else
            begin
                due_word = pending_digest.pop_front();
                if (out_data.digest_word !== due_word.digest_word)
                begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             due_word.digest_word, out_data.digest_word);
                    errors++;
                end
                if (out_data.digest_position !== due_word.digest_position)
                begin
                    $display("%0t: digest_position expected %0d actual %0d", $time,
                             due_word.digest_position, out_data.digest_position);
                    errors++;
                end
                if (out_data.last !== due_word.last)
                begin
                    $display("%0t: last expected %b actual %b", $time,
                             due_word.last, out_data.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin : rx_pattern
        int  hold_left;
        int  run_left;
        bit  level;
        hold_left = 0;
        run_left  = 0;
        level     = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_request > 0)
            begin
                hold_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_steady)
                out_ready <= 1'b1;
            else
            begin
                if (run_left == 0)
                begin
                    level = !level;
                    run_left = level ? $urandom_range(10, 1) : $urandom_range(5, 1);
                end
                run_left--;
                out_ready <= level;
            end
        end
    end

    task automatic test_reset_state();
        send_word(KIND_READ, $urandom, 3'($urandom_range(7)));
        send_word(KIND_UNUSED, 32'hFFFFFFFF, 3'd7);
        send_word(KIND_READ, 32'h0, 3'd0);
        wait_for_digests();
    endtask

    // Padded single block of the three-letter message "abc".
    task automatic test_known_block();
        send_word(KIND_ABSORB, 32'h61626380, 3'd0);
        for (int i = 1; i < 15; i++)
            send_word(KIND_ABSORB, 32'h0, 3'($urandom_range(7)));
        send_word(KIND_ABSORB, 32'h00000018, 3'd7);
        send_word(KIND_READ, $urandom, 3'd0);
        wait_for_digests();
    endtask

    // Load and read while a block holds only one absorbed word; the block completes later.
    task automatic test_partial_block();
        send_word(KIND_ABSORB, 32'hFFFFFFFF, 3'd0);
        send_word(KIND_LOAD, 32'hFFFFFFFF, 3'd7);
        send_word(KIND_LOAD, 32'h0, 3'd0);
        send_word(KIND_READ, $urandom, 3'($urandom_range(7)));
        wait_for_digests();
    endtask

    // Hold the output off long enough that reads back up into the input.
    task automatic test_output_backpressure();
        rx_hold_request = 250;
        sender_steady = 1'b1;
        for (int i = 0; i < 6; i++)
            send_word(KIND_READ, $urandom, 3'($urandom_range(7)));
        for (int i = 0; i < 4; i++)
            send_word(KIND_ABSORB, $urandom, 3'($urandom_range(7)));
        send_word(KIND_READ, $urandom, 3'($urandom_range(7)));
        sender_steady = 1'b0;
        wait_for_digests();
    endtask

    task automatic test_random_traffic();
        int counted;
        int pick;
        int sel;
        logic [31:0] word;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            if (counted % 50 == 0)
            begin
                sender_steady = ($urandom_range(3) == 0);
                rx_steady     = ($urandom_range(3) == 0);
            end
            sel  = $urandom_range(15);
            word = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFFFFFF : $urandom;
            pick = $urandom_range(99);
            if (pick < 70)
                send_word(KIND_ABSORB, word, 3'($urandom_range(7)));
            else if (pick < 82)
                send_word(KIND_LOAD, word, 3'($urandom_range(7)));
            else if (pick < 92)
                send_word(KIND_READ, word, 3'($urandom_range(7)));
            else
                send_word(KIND_UNUSED, word, 3'($urandom_range(7)));
            counted++;
        end
        sender_steady = 1'b0;
        rx_steady     = 1'b0;
        wait_for_digests();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        chain_model = START_VALUE;
        block_fill = 4'd0;
        for (int i = 0; i < 16; i++)
            block_words[i] = 32'h0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_known_block();
        test_partial_block();
        test_output_backpressure();
        test_random_traffic();

        wait_for_digests();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
